// File: src/i2cm_pkg.sv
package i2cm_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_DEVICE_ADDRESS = 8'd0;
  localparam logic [7:0] REG_STRETCH_LIMIT  = 8'd1;

  localparam logic [7:0] STRETCH_LIMIT_RST = 8'd10;
  localparam logic [7:0] ADDR_READ_BIT     = 8'h01;

  // Command codes
  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_STOP      = 3'd1;
  localparam logic [2:0] OP_SEND      = 3'd2;
  localparam logic [2:0] OP_RECV      = 3'd3;
  localparam logic [2:0] OP_WR_SINGLE = 3'd4;
  localparam logic [2:0] OP_WR_REG    = 3'd5;
  localparam logic [2:0] OP_RD_REG    = 3'd6;
  localparam logic [2:0] OP_INVALID   = 3'd7;

  // Completion status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NACK    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // Segment codes of a command program
  typedef enum logic [3:0] {
    SEG_END,
    SEG_START,
    SEG_STOP,
    SEG_TX_DATA,
    SEG_TX_REG,
    SEG_TX_ADDR,
    SEG_TX_ADDR_RD,
    SEG_RX,
    SEG_RX_NACK
  } seg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] tx_data;
    logic [7:0] reg_index;
    logic       send_nack;
    logic       scl_sense;
    logic       sda_sense;
  } item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rx_byte;
    logic       ack_bit;
    logic       bus_active;
  } res_t;

  // Segment sequence of each command
  function automatic seg_t prog_code(input logic [2:0] op, input logic [2:0] step);
    seg_t code;
    code = SEG_END;
    case (op)
      OP_START:  if (step == 3'd0) code = SEG_START;
      OP_STOP:   if (step == 3'd0) code = SEG_STOP;
      OP_SEND:   if (step == 3'd0) code = SEG_TX_DATA;
      OP_RECV:   if (step == 3'd0) code = SEG_RX;
      OP_WR_SINGLE: begin
        case (step)
          3'd0:    code = SEG_START;
          3'd1:    code = SEG_TX_ADDR;
          3'd2:    code = SEG_TX_DATA;
          3'd3:    code = SEG_STOP;
          default: code = SEG_END;
        endcase
      end
      OP_WR_REG: begin
        case (step)
          3'd0:    code = SEG_START;
          3'd1:    code = SEG_TX_ADDR;
          3'd2:    code = SEG_TX_REG;
          3'd3:    code = SEG_TX_DATA;
          3'd4:    code = SEG_STOP;
          default: code = SEG_END;
        endcase
      end
      OP_RD_REG: begin
        case (step)
          3'd0:    code = SEG_START;
          3'd1:    code = SEG_TX_ADDR;
          3'd2:    code = SEG_TX_REG;
          3'd3:    code = SEG_START;
          3'd4:    code = SEG_TX_ADDR_RD;
          3'd5:    code = SEG_RX_NACK;
          3'd6:    code = SEG_STOP;
          default: code = SEG_END;
        endcase
      end
      default: code = SEG_END;
    endcase
    return code;
  endfunction

endpackage

// File: src/i2cm_ifs.sv
interface i2cm_item_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] operation;
  logic [7:0] tx_data;
  logic [7:0] reg_index;
  logic       send_nack;
  logic       scl_sense;
  logic       sda_sense;

  modport source (output valid, cmd_valid, operation, tx_data, reg_index, send_nack,
                  scl_sense, sda_sense, input ready);
  modport sink (input valid, cmd_valid, operation, tx_data, reg_index, send_nack,
                scl_sense, sda_sense, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_drive_low;
  logic       sda_drive_low;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] rx_byte;
  logic       ack_bit;
  logic       bus_active;

  modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res, status,
                  rx_byte, ack_bit, bus_active, input ready);
  modport sink (input valid, scl_drive_low, sda_drive_low, busy_res, done_res, status,
                rx_byte, ack_bit, bus_active, output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/i2cm_engine.sv
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  item_t      item,
  input  logic [7:0] device_address,
  input  logic [7:0] stretch_limit,
  output res_t       res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_S_RELSDA,
    PH_S_RELSCL,
    PH_S_WAIT,
    PH_S_ASDA,
    PH_S_ASCL,
    PH_P_ASDA,
    PH_P_RELSCL,
    PH_P_WAIT,
    PH_P_RELSDA,
    PH_B_SDA,
    PH_B_RELSCL,
    PH_B_WAIT
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] step;
    logic [3:0] bit_count;
    logic [7:0] shift;
    logic [7:0] stretch;
    logic       active;
    logic [7:0] tx;
    logic [7:0] reg_idx;
    logic       nack;
    logic       scl_low;
    logic       sda_low;
    logic [2:0] run_op;
    seg_t       seg;
    logic [1:0] status;
    logic [7:0] rx;
    logic       ack;
  } eng_t;

  eng_t st;
  eng_t st_next;
  logic is_rx;
  logic nack_bit;

  // Load the segment at the current program step
  function automatic eng_t load_seg(input eng_t s, input logic [7:0] dev);
    seg_t code;
    code = prog_code(s.run_op, s.step);
    s.seg = code;
    s.bit_count = 4'd0;
    unique case (code)
      SEG_START:      s.phase = s.active ? PH_S_RELSDA : PH_S_ASDA;
      SEG_STOP:       s.phase = PH_P_ASDA;
      SEG_TX_DATA: begin
        s.shift = s.tx;
        s.phase = PH_B_SDA;
      end
      SEG_TX_REG: begin
        s.shift = s.reg_idx;
        s.phase = PH_B_SDA;
      end
      SEG_TX_ADDR: begin
        s.shift = dev;
        s.phase = PH_B_SDA;
      end
      SEG_TX_ADDR_RD: begin
        s.shift = dev | ADDR_READ_BIT;
        s.phase = PH_B_SDA;
      end
      SEG_RX, SEG_RX_NACK: begin
        s.shift = 8'd0;
        s.phase = PH_B_SDA;
      end
      default: begin
        s.status = ST_OK;
        s.phase = PH_IDLE;
      end
    endcase
    return s;
  endfunction

  // Count one tick of SCL held low by a slave; give up at the limit
  function automatic eng_t stretch_tick(input eng_t s, input logic [7:0] lim);
    if (s.stretch != 8'hFF) begin
      s.stretch = s.stretch + 8'd1;
    end
    if (s.stretch >= lim) begin
      s.status = ST_TIMEOUT;
      s.phase = PH_IDLE;
    end
    return s;
  endfunction

  assign is_rx = (st.seg == SEG_RX) || (st.seg == SEG_RX_NACK);
  assign nack_bit = (st.seg == SEG_RX_NACK) ? 1'b1 : st.nack;

  // Advance the bus sequencer by one tick
  always_comb begin
    st_next = st;
    unique case (st.phase)
      PH_IDLE: begin
        if (item.cmd_valid && item.operation != OP_INVALID) begin
          st_next.tx = item.tx_data;
          st_next.reg_idx = item.reg_index;
          st_next.nack = item.send_nack;
          st_next.run_op = item.operation;
          st_next.step = 3'd0;
          st_next = load_seg(st_next, device_address);
        end
      end
      PH_S_RELSDA: begin
        st_next.sda_low = 1'b0;
        st_next.phase = PH_S_RELSCL;
      end
      PH_S_RELSCL: begin
        st_next.scl_low = 1'b0;
        st_next.stretch = 8'd0;
        st_next.phase = PH_S_WAIT;
      end
      PH_S_WAIT: begin
        if (item.scl_sense) begin
          st_next.phase = PH_S_ASDA;
        end else begin
          st_next = stretch_tick(st_next, stretch_limit);
        end
      end
      PH_S_ASDA: begin
        st_next.sda_low = 1'b1;
        st_next.phase = PH_S_ASCL;
      end
      PH_S_ASCL: begin
        st_next.scl_low = 1'b1;
        st_next.active = 1'b1;
        st_next.step = st.step + 3'd1;
        st_next = load_seg(st_next, device_address);
      end
      PH_P_ASDA: begin
        st_next.sda_low = 1'b1;
        st_next.phase = PH_P_RELSCL;
      end
      PH_P_RELSCL: begin
        st_next.scl_low = 1'b0;
        st_next.stretch = 8'd0;
        st_next.phase = PH_P_WAIT;
      end
      PH_P_WAIT: begin
        if (item.scl_sense) begin
          st_next.phase = PH_P_RELSDA;
        end else begin
          st_next = stretch_tick(st_next, stretch_limit);
        end
      end
      PH_P_RELSDA: begin
        st_next.sda_low = 1'b0;
        st_next.active = 1'b0;
        st_next.step = st.step + 3'd1;
        st_next = load_seg(st_next, device_address);
      end
      PH_B_SDA: begin
        if (st.bit_count < 4'd8) begin
          st_next.sda_low = is_rx ? 1'b0 : ~st.shift[7];
        end else begin
          st_next.sda_low = is_rx ? ~nack_bit : 1'b0;
        end
        st_next.phase = PH_B_RELSCL;
      end
      PH_B_RELSCL: begin
        st_next.scl_low = 1'b0;
        st_next.stretch = 8'd0;
        st_next.phase = PH_B_WAIT;
      end
      PH_B_WAIT: begin
        if (item.scl_sense) begin
          if (st.bit_count < 4'd8) begin
            st_next.shift = {st.shift[6:0], is_rx & item.sda_sense};
          end else if (!is_rx) begin
            st_next.ack = item.sda_sense;
          end
          st_next.scl_low = 1'b1;
          st_next.bit_count = st.bit_count + 4'd1;
          if (st_next.bit_count >= 4'd9) begin
            if (is_rx) begin
              st_next.rx = st_next.shift;
              st_next.step = st.step + 3'd1;
              st_next = load_seg(st_next, device_address);
            end else if (st_next.ack) begin
              st_next.status = ST_NACK;
              st_next.phase = PH_IDLE;
            end else begin
              st_next.step = st.step + 3'd1;
              st_next = load_seg(st_next, device_address);
            end
          end else begin
            st_next.phase = PH_B_SDA;
          end
        end else begin
          st_next = stretch_tick(st_next, stretch_limit);
        end
      end
      default: st_next.phase = PH_IDLE;
    endcase
  end

  // Result word reflects the state after this tick
  always_comb begin
    res.scl_drive_low = st_next.scl_low;
    res.sda_drive_low = st_next.sda_low;
    res.busy_res      = (st_next.phase != PH_IDLE);
    res.done_res      = (st.phase != PH_IDLE) && (st_next.phase == PH_IDLE);
    res.status        = st_next.status;
    res.rx_byte       = st_next.rx;
    res.ack_bit       = st_next.ack;
    res.bus_active    = st_next.active;
  end

  // Hold sequencer state; advance once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

// File: src/i2c_master_byte_engine_core.sv
// I2C master byte engine: one bus tick per input word.
// The result word for a tick is registered and appears in the cycle after the tick is accepted.
// Throughput: one tick per clock; the output register is reloaded in the cycle
// its word is taken, so only output backpressure stalls input.
// Reset (synchronous, rst high): sequencer idle, both lines released, status,
// received byte and ack cleared, device_address 0, stretch_limit 10.
module i2c_master_byte_engine_core
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  i2cm_item_if.sink  in_ch,
  i2cm_res_if.source out_ch,
  i2cm_cfg_if.sink   cfg
);

  logic [7:0] device_address;
  logic [7:0] stretch_limit;
  logic       accept;
  item_t      item;
  res_t       res_next;
  res_t       res_q;
  logic       res_valid;

  // Pack the incoming word
  assign item.cmd_valid = in_ch.cmd_valid;
  assign item.operation = in_ch.operation;
  assign item.tx_data   = in_ch.tx_data;
  assign item.reg_index = in_ch.reg_index;
  assign item.send_nack = in_ch.send_nack;
  assign item.scl_sense = in_ch.scl_sense;
  assign item.sda_sense = in_ch.sda_sense;

  // Take a new word when the output register is empty or draining
  assign in_ch.ready = !res_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  i2cm_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .device_address (device_address),
    .stretch_limit  (stretch_limit),
    .res            (res_next)
  );

  // Write configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= 8'd0;
      stretch_limit  <= STRETCH_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEVICE_ADDRESS: device_address <= cfg.data;
        REG_STRETCH_LIMIT:  stretch_limit  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_next;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.scl_drive_low = res_q.scl_drive_low;
  assign out_ch.sda_drive_low = res_q.sda_drive_low;
  assign out_ch.busy_res      = res_q.busy_res;
  assign out_ch.done_res      = res_q.done_res;
  assign out_ch.status        = res_q.status;
  assign out_ch.rx_byte       = res_q.rx_byte;
  assign out_ch.ack_bit       = res_q.ack_bit;
  assign out_ch.bus_active    = res_q.bus_active;

endmodule

// File: src/i2cm_checker.sv
module i2cm_checker
  import i2cm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       busy_res,
  input logic       done_res,
  input logic [1:0] status,
  input logic       ack_bit
);

  // Output register empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds its flags
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(done_res) && $stable(status))
    else $error("stalled result word changed");

  // Input is taken whenever no result is pending
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // A finished command leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while busy");

  // Finishing on a NACK shows the NACK bit
  a_nack_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res && status == ST_NACK |-> ack_bit)
    else $error("NACK status without NACK bit");

endmodule

bind i2c_master_byte_engine_core i2cm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .status    (out_ch.status),
  .ack_bit   (out_ch.ack_bit)
);
